// File: rtl/hae_pkg.sv
// shared constants, codes and power table builder for the histogram auto exposure block
package hae_pkg;

   localparam int MAX_REGIONS       = 4;
   localparam int BAND_COUNT        = 5;
   localparam int PIXEL_BINS        = 256;
   localparam int PIXEL_COUNT_BITS  = 20;
   localparam int POWER_TABLE_DEPTH = 1024;

   localparam int PIXEL_W    = 16;
   localparam int EXPO_W     = 20;
   localparam int EXPO_LIMIT = 1000000;
   localparam int TENTH_Q16     = 6554;
   localparam int TWENTIETH_Q16 = 3277;
   localparam logic [15:0] EXP_FRAC_Q16 = 16'hA666;

   localparam int CMD_W = 2;
   localparam logic [CMD_W-1:0] CMD_START  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PIXEL  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FINISH = 2'd2;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int REG_IDX_W  = 3;
   localparam logic [REG_IDX_W-1:0] REG_DARK_LIMIT   = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_BRIGHT_START = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_CLIP_FRAC    = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_CLIP_GAIN    = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_MEAN_GAIN    = 3'd4;

   localparam int BIN_W     = $clog2(PIXEL_BINS);
   localparam int BAND_W    = $clog2(BAND_COUNT);
   localparam int BAND_STEP = 65536 / BAND_COUNT;
   localparam int SUM_W     = 36;
   localparam int NUM_W     = SUM_W + $clog2(BAND_COUNT * (BAND_COUNT + 1) / 2 + 1);
   localparam int DEN_W     = SUM_W + $clog2(BAND_COUNT + 1);
   localparam int DVD_W     = NUM_W + 16;
   localparam int DVS_W     = DEN_W;
   localparam int QCNT_W    = $clog2(DVD_W);
   localparam int FRAC_W    = PIXEL_COUNT_BITS + 17;
   localparam int ERR_W     = FRAC_W + 1;
   localparam int MEAN_W    = $clog2(BAND_COUNT * 65536 + 1);
   localparam int E_W       = MEAN_W + 1;
   localparam int SQ_W      = 2 * MEAN_W;
   localparam int PROD_W    = 20 + SQ_W;
   localparam int STEP_W    = PROD_W - 32;
   localparam int TOTAL_W   = 23;
   localparam int ACT_W     = 3;
   localparam int POW_W     = 17;
   localparam int POW_AW    = $clog2(POWER_TABLE_DEPTH + 1);

   typedef logic [POW_W-1:0] pow_rom_type [0:POWER_TABLE_DEPTH];

   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] x;
      logic [63:0] r;
      logic [63:0] b;
      x = v;
      r = 64'd0;
      b = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (b > x) b = b >> 2;
      end
      for (int i = 0; i < 32; i++) begin
         if (b != 64'd0) begin
            if (x >= r + b) begin
               x = x - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
      end
      return r;
   endfunction

   // x^1.65 as x times a product of repeated square roots
   function automatic pow_rom_type pow_rom_build();
      pow_rom_type t;
      logic [63:0] x;
      logic [63:0] s;
      logic [63:0] acc;
      logic [63:0] y;
      for (int i = 0; i <= POWER_TABLE_DEPTH; i++) begin
         x = (64'(i) << 30) / POWER_TABLE_DEPTH;
         s = x;
         acc = 64'd1 << 30;
         for (int k = 1; k <= 16; k++) begin
            s = isqrt64(s << 30);
            if (EXP_FRAC_Q16[16-k]) acc = (acc * s) >> 30;
         end
         y = (x * acc) >> 30;
         t[i] = POW_W'((y + (64'd1 << 13)) >> 14);
      end
      return t;
   endfunction

endpackage

// File: rtl/hae_req_if.sv
// input item channel
interface hae_req_if;
   logic                          valid;
   logic                          ready;
   logic [hae_pkg::CMD_W-1:0]     cmd;
   logic [hae_pkg::PIXEL_W-1:0]   pixel_value;
   logic                          region_end;
   logic [hae_pkg::EXPO_W-1:0]    frame_exposure;
   logic [hae_pkg::EXPO_W-1:0]    last_set_exposure;

   modport source (output valid, cmd, pixel_value, region_end, frame_exposure,
                   last_set_exposure, input ready);
   modport sink (input valid, cmd, pixel_value, region_end, frame_exposure,
                 last_set_exposure, output ready);
endinterface

// File: rtl/hae_rsp_if.sv
// result item channel
interface hae_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [hae_pkg::EXPO_W-1:0]  new_exposure;
   logic                        exposure_changed;

   modport source (output valid, new_exposure, exposure_changed, input ready);
   modport sink (input valid, new_exposure, exposure_changed, output ready);
endinterface

// File: rtl/histogram_auto_exposure_top.sv
// histogram auto exposure controller: pixel statistics, region proposals, frame mean
// start items and pixel items without region end leave the block idle, so ready stays high
// region end runs a shared 56-step restoring divider: two divisions and a clip multiply on the clip path,
// four divisions plus sum and multiply steps on the mean band path
// finish returns a result directly, or first runs the mean division when it applies; no item while a result waits
// synchronous active high reset restores register defaults and clears all statistics
module histogram_auto_exposure_top (
   input  logic                              clock,
   input  logic                              reset,
   hae_req_if.sink                           req_bus,
   hae_rsp_if.source                         rsp_bus,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [hae_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [hae_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [hae_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import hae_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DIV, S_DONE, S_CLASS, S_CLIPMUL, S_SUM, S_SQ, S_MULH, S_MULL, S_STEP
   } state_type;
   typedef enum logic [2:0] {PH_LO, PH_HI, PH_MEAN, PH_STEPDIV, PH_FIN} phase_type;
   typedef enum logic [1:0] {MODE_UP, MODE_DOWN, MODE_KEEP} mode_type;

   localparam pow_rom_type POW_ROM = pow_rom_build();

   logic [8:0]  dark_limit_ff, bright_start_ff;
   logic [15:0] clip_frac_ff;
   logic [19:0] clip_gain_ff, mean_gain_ff;

   logic [PIXEL_COUNT_BITS-1:0] dark_cnt_ff, bright_cnt_ff, pix_cnt_ff;
   logic [SUM_W-1:0]            band_ff [BAND_COUNT];
   logic [TOTAL_W-1:0]          total_ff;
   logic [ACT_W-1:0]            active_ff;
   logic [EXPO_W-1:0]           last_ff;
   logic                        match_ff;

   state_type                   state_ff;
   phase_type                   phase_ff;
   mode_type                    mode_ff;
   logic [DVD_W-1:0]            div_q_ff;
   logic [DVS_W-1:0]            div_d_ff;
   logic [DVS_W:0]              div_r_ff;
   logic [QCNT_W-1:0]           div_cnt_ff;
   logic [FRAC_W-1:0]           flo_ff, fhi_ff;
   logic [3:0]                  divsel_ff;
   logic [NUM_W-1:0]            num_acc_ff;
   logic [DEN_W-1:0]            den_acc_ff;
   logic [BAND_W-1:0]           sum_idx_ff;
   logic signed [E_W-1:0]       e_ff;
   logic [SQ_W-1:0]             sq_ff;
   logic [PROD_W-1:0]           prod_ff;
   logic [STEP_W-1:0]           step_ff;
   logic [POW_W-1:0]            pow_q_ff;
   logic                        rsp_valid_ff, rsp_chg_ff;
   logic [EXPO_W-1:0]           rsp_exp_ff;

   logic                        req_ready, acc;
   logic [BIN_W-1:0]            bin;
   logic [BAND_W-1:0]           band_c, rd_idx;
   logic [SUM_W-1:0]            band_rd;
   logic [SUM_W:0]              band_add;
   logic [SUM_W-1:0]            band_in;
   logic                        dark_hit, bright_hit;
   logic [PIXEL_COUNT_BITS-1:0] pix_div;
   logic [DVS_W:0]              div_shift, div_r_in;
   logic                        div_ge;
   logic signed [ERR_W-1:0]     elo, ehi, alo, ahi;
   logic                        under, over;
   logic [ERR_W-1:0]            err_u;
   logic [ERR_W+POW_AW-1:0]     idx_full;
   logic [POW_AW-1:0]           pow_addr;
   logic [36:0]                 cprod;
   logic [NUM_W-1:0]            num_in;
   logic [DEN_W-1:0]            den_in;
   logic [MEAN_W-1:0]           ae;
   logic [PROD_W-1:0]           prod_in;
   logic [STEP_W:0]             up_v;
   logic [EXPO_W-1:0]           prop;
   logic [TOTAL_W-1:0]          mean;

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign req_bus.ready = req_ready;
   assign acc = req_bus.valid && req_ready;

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.new_exposure     = rsp_exp_ff;
   assign rsp_bus.exposure_changed = rsp_chg_ff;

   assign bin        = req_bus.pixel_value[PIXEL_W-1 -: BIN_W];
   assign dark_hit   = (11'(bin) < 11'(dark_limit_ff));
   assign bright_hit = (11'(bin) >= 11'(bright_start_ff));

   always_comb begin
      band_c = '0;
      for (int k = 1; k < BAND_COUNT; k++) begin
         if (17'(req_bus.pixel_value) >= 17'(k * BAND_STEP)) band_c = BAND_W'(k);
      end
   end

   assign rd_idx   = (state_ff == S_IDLE) ? band_c : sum_idx_ff;
   assign band_rd  = band_ff[rd_idx];
   assign band_add = {1'b0, band_rd} + (SUM_W+1)'(req_bus.pixel_value);
   assign band_in  = band_add[SUM_W] ? {SUM_W{1'b1}} : band_add[SUM_W-1:0];
   assign pix_div  = (pix_cnt_ff == '0) ? PIXEL_COUNT_BITS'(1) : pix_cnt_ff;

   // shared restoring divider step
   assign div_shift = {div_r_ff[DVS_W-1:0], div_q_ff[DVD_W-1]};
   assign div_ge    = div_shift >= {1'b0, div_d_ff};
   assign div_r_in  = div_ge ? div_shift - {1'b0, div_d_ff} : div_shift;

   assign elo   = $signed({1'b0, flo_ff}) - $signed(ERR_W'(clip_frac_ff));
   assign ehi   = $signed({1'b0, fhi_ff}) - $signed(ERR_W'(clip_frac_ff));
   assign alo   = elo[ERR_W-1] ? -elo : elo;
   assign ahi   = ehi[ERR_W-1] ? -ehi : ehi;
   assign under = !elo[ERR_W-1] && ehi[ERR_W-1];
   assign over  = !ehi[ERR_W-1] && elo[ERR_W-1];
   assign err_u = under ? elo : ehi;
   assign idx_full = ((ERR_W+POW_AW)'(err_u) * (ERR_W+POW_AW)'(POWER_TABLE_DEPTH)) >> 16;
   assign pow_addr = (idx_full > (ERR_W+POW_AW)'(POWER_TABLE_DEPTH)) ?
                     POW_AW'(POWER_TABLE_DEPTH) : idx_full[POW_AW-1:0];
   assign cprod = 37'(clip_gain_ff) * 37'(pow_q_ff);

   assign num_in = num_acc_ff + NUM_W'(band_rd) * NUM_W'({1'b0, sum_idx_ff} + 1'b1);
   assign den_in = den_acc_ff + DEN_W'(band_rd);
   assign ae = MEAN_W'(e_ff[E_W-1] ? -e_ff : e_ff);
   assign prod_in = prod_ff + PROD_W'(mean_gain_ff) * PROD_W'(sq_ff[MEAN_W-1:0]);
   assign mean = div_q_ff[TOTAL_W-1:0];

   always_comb begin
      up_v = {1'b0, step_ff} + (STEP_W+1)'(last_ff);
      if (step_ff == '0) up_v = (STEP_W+1)'(last_ff) + 1'b1;
      unique case (mode_ff)
         MODE_UP: begin
            prop = (up_v > (STEP_W+1)'(EXPO_LIMIT)) ? EXPO_W'(EXPO_LIMIT) : up_v[EXPO_W-1:0];
         end
         MODE_DOWN: begin
            if (step_ff == '0)
               prop = (last_ff <= EXPO_W'(1)) ? EXPO_W'(1) : last_ff - 1'b1;
            else if (step_ff >= STEP_W'(last_ff))
               prop = EXPO_W'(1);
            else
               prop = last_ff - step_ff[EXPO_W-1:0];
         end
         default: prop = last_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      pow_q_ff <= POW_ROM[pow_addr];
   end

   // configuration registers
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         dark_limit_ff   <= 9'd25;
         bright_start_ff <= 9'd230;
         clip_frac_ff    <= 16'd21627;
         clip_gain_ff    <= 20'd14000;
         mean_gain_ff    <= 20'd100;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_paddr[CSR_ADDR_W-1:2])
            REG_DARK_LIMIT:   dark_limit_ff   <= csr_pwdata[8:0];
            REG_BRIGHT_START: bright_start_ff <= csr_pwdata[8:0];
            REG_CLIP_FRAC:    clip_frac_ff    <= csr_pwdata[15:0];
            REG_CLIP_GAIN:    clip_gain_ff    <= csr_pwdata[19:0];
            REG_MEAN_GAIN:    mean_gain_ff    <= csr_pwdata[19:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[CSR_ADDR_W-1:2])
         REG_DARK_LIMIT:   csr_prdata = CSR_DATA_W'(dark_limit_ff);
         REG_BRIGHT_START: csr_prdata = CSR_DATA_W'(bright_start_ff);
         REG_CLIP_FRAC:    csr_prdata = CSR_DATA_W'(clip_frac_ff);
         REG_CLIP_GAIN:    csr_prdata = CSR_DATA_W'(clip_gain_ff);
         REG_MEAN_GAIN:    csr_prdata = CSR_DATA_W'(mean_gain_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_LO;
         mode_ff      <= MODE_KEEP;
         rsp_valid_ff <= 1'b0;
         dark_cnt_ff  <= '0;
         bright_cnt_ff <= '0;
         pix_cnt_ff   <= '0;
         for (int b = 0; b < BAND_COUNT; b++) band_ff[b] <= '0;
         total_ff     <= '0;
         active_ff    <= '0;
         last_ff      <= '0;
         match_ff     <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_bus.ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (acc) begin
                  if (req_bus.cmd == CMD_START) begin
                     last_ff   <= req_bus.last_set_exposure;
                     match_ff  <= (req_bus.frame_exposure == req_bus.last_set_exposure);
                     total_ff  <= '0;
                     active_ff <= '0;
                  end else if (req_bus.cmd == CMD_PIXEL) begin
                     if (req_bus.region_end && active_ff >= ACT_W'(MAX_REGIONS)) begin
                        dark_cnt_ff   <= '0;
                        bright_cnt_ff <= '0;
                        pix_cnt_ff    <= '0;
                        for (int b = 0; b < BAND_COUNT; b++) band_ff[b] <= '0;
                     end else begin
                        if (!(&pix_cnt_ff)) pix_cnt_ff <= pix_cnt_ff + 1'b1;
                        if (dark_hit && !(&dark_cnt_ff)) dark_cnt_ff <= dark_cnt_ff + 1'b1;
                        if (bright_hit && !(&bright_cnt_ff))
                           bright_cnt_ff <= bright_cnt_ff + 1'b1;
                        band_ff[band_c] <= band_in;
                        if (req_bus.region_end) begin
                           // pixel counters settle this edge; S_DONE then loads the dark fraction division
                           state_ff <= S_DONE;
                           phase_ff <= PH_LO;
                           mode_ff  <= MODE_KEEP;
                        end
                     end
                  end else if (req_bus.cmd == CMD_FINISH) begin
                     if (match_ff && active_ff != '0) begin
                        div_q_ff   <= DVD_W'(total_ff);
                        div_d_ff   <= DVS_W'(active_ff);
                        div_r_ff   <= '0;
                        div_cnt_ff <= '0;
                        phase_ff   <= PH_FIN;
                        state_ff   <= S_DIV;
                     end else begin
                        rsp_exp_ff   <= '0;
                        rsp_chg_ff   <= 1'b0;
                        rsp_valid_ff <= 1'b1;
                     end
                  end
               end
            end
            S_DIV: begin
               div_r_ff <= div_r_in;
               div_q_ff <= {div_q_ff[DVD_W-2:0], div_ge};
               div_cnt_ff <= div_cnt_ff + 1'b1;
               if (div_cnt_ff == QCNT_W'(DVD_W - 1)) state_ff <= S_DONE;
            end
            S_DONE: begin
               unique case (phase_ff)
                  PH_LO: begin
                     if (mode_ff == MODE_KEEP) begin
                        // region entry: load dark fraction division
                        div_q_ff <= DVD_W'({dark_cnt_ff, 16'd0});
                        mode_ff  <= MODE_UP;
                     end else begin
                        flo_ff   <= div_q_ff[FRAC_W-1:0];
                        div_q_ff <= DVD_W'({bright_cnt_ff, 16'd0});
                        phase_ff <= PH_HI;
                     end
                     div_d_ff   <= DVS_W'(pix_div);
                     div_r_ff   <= '0;
                     div_cnt_ff <= '0;
                     state_ff   <= S_DIV;
                  end
                  PH_HI: begin
                     fhi_ff   <= div_q_ff[FRAC_W-1:0];
                     state_ff <= S_CLASS;
                  end
                  PH_MEAN: begin
                     e_ff <= $signed(E_W'(BAND_COUNT * 32768)) -
                             $signed({1'b0, div_q_ff[MEAN_W-1:0]});
                     state_ff <= S_SQ;
                  end
                  PH_STEPDIV: begin
                     step_ff <= div_q_ff[STEP_W-1:0];
                     if (e_ff >= $signed(E_W'(TENTH_Q16)))
                        mode_ff <= MODE_UP;
                     else if (e_ff <= -$signed(E_W'(TENTH_Q16)))
                        mode_ff <= MODE_DOWN;
                     else
                        mode_ff <= MODE_KEEP;
                     state_ff <= S_STEP;
                  end
                  PH_FIN: begin
                     if (mean != TOTAL_W'(last_ff)) begin
                        rsp_exp_ff <= mean[EXPO_W-1:0];
                        rsp_chg_ff <= 1'b1;
                     end else begin
                        rsp_exp_ff <= '0;
                        rsp_chg_ff <= 1'b0;
                     end
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_IDLE;
                  end
                  default: state_ff <= S_IDLE;
               endcase
            end
            S_CLASS: begin
               if (alo < $signed(ERR_W'(TWENTIETH_Q16)) || ahi < $signed(ERR_W'(TWENTIETH_Q16)))
                  divsel_ff <= 4'd10;
               else if (alo < $signed(ERR_W'(TENTH_Q16)) || ahi < $signed(ERR_W'(TENTH_Q16)))
                  divsel_ff <= 4'd5;
               else
                  divsel_ff <= 4'd1;
               if (under || over) begin
                  state_ff <= S_CLIPMUL;
               end else begin
                  num_acc_ff <= '0;
                  den_acc_ff <= '0;
                  sum_idx_ff <= '0;
                  state_ff   <= S_SUM;
               end
            end
            S_CLIPMUL: begin
               step_ff  <= STEP_W'(cprod >> 16);
               mode_ff  <= under ? MODE_UP : MODE_DOWN;
               state_ff <= S_STEP;
            end
            S_SUM: begin
               num_acc_ff <= num_in;
               den_acc_ff <= den_in;
               sum_idx_ff <= sum_idx_ff + 1'b1;
               if (sum_idx_ff == BAND_W'(BAND_COUNT - 1)) begin
                  div_q_ff   <= {num_in, 16'd0};
                  div_d_ff   <= (den_in == '0) ? DVS_W'(1) : DVS_W'(den_in);
                  div_r_ff   <= '0;
                  div_cnt_ff <= '0;
                  phase_ff   <= PH_MEAN;
                  state_ff   <= S_DIV;
               end
            end
            S_SQ: begin
               sq_ff    <= SQ_W'(ae) * SQ_W'(ae);
               state_ff <= S_MULH;
            end
            S_MULH: begin
               prod_ff  <= (PROD_W'(mean_gain_ff) * PROD_W'(sq_ff[SQ_W-1:MEAN_W])) << MEAN_W;
               state_ff <= S_MULL;
            end
            S_MULL: begin
               div_q_ff   <= DVD_W'(prod_in >> 32);
               div_d_ff   <= DVS_W'(divsel_ff);
               div_r_ff   <= '0;
               div_cnt_ff <= '0;
               phase_ff   <= PH_STEPDIV;
               state_ff   <= S_DIV;
            end
            S_STEP: begin
               total_ff      <= total_ff + TOTAL_W'(prop);
               active_ff     <= active_ff + 1'b1;
               dark_cnt_ff   <= '0;
               bright_cnt_ff <= '0;
               pix_cnt_ff    <= '0;
               for (int b = 0; b < BAND_COUNT; b++) band_ff[b] <= '0;
               mode_ff  <= MODE_KEEP;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// File: rtl/hae_checker.sv
// port level checks for the histogram auto exposure top, attached by bind
module hae_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [hae_pkg::CMD_W-1:0]     req_cmd,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [hae_pkg::EXPO_W-1:0]    rsp_new_exposure,
   input logic                          rsp_exposure_changed
);
   import hae_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   a_no_change_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_exposure_changed |-> rsp_new_exposure == '0)
      else $error("no change item carries a value");

   a_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_exposure_changed |-> rsp_new_exposure <= EXPO_W'(EXPO_LIMIT))
      else $error("exposure above limit");

   a_only_finish: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_cmd != CMD_FINISH |=> !$rose(rsp_valid))
      else $error("result item after a non finish item");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind histogram_auto_exposure_top hae_checker u_hae_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_bus.valid),
   .req_ready            (req_bus.ready),
   .req_cmd              (req_bus.cmd),
   .rsp_valid            (rsp_bus.valid),
   .rsp_ready            (rsp_bus.ready),
   .rsp_new_exposure     (rsp_bus.new_exposure),
   .rsp_exposure_changed (rsp_bus.exposure_changed)
);
